@@ hdl/lcb_pkg.sv @@
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared types and constants of the byte-budget LRU cache: sequencer states,
// shared-unit operations and result bundle, default sizes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lcb_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int SIZE_W  = 32;
  localparam int STAMP_W = 64;
  localparam int UNIT_W  = 64;

  localparam logic [31:0] CAPACITY_RESET = 32'd1048576;

  // Register index of capacity_bytes (address bit 2 selects the register).
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_FIT,
    S_OLD,
    S_DROP,
    S_STORE,
    S_DONE
  } state_t;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } unit_op_t;

  typedef struct packed {
    logic              eq;
    logic              lt;
    logic [UNIT_W-1:0] res;
  } unit_res_t;

endpackage

`default_nettype wire

@@ hdl/lcb_unit.sv @@
// ----------------------------------------------------------------------------
// lcb_unit
// Shared compare and add/subtract unit. Key match, stamp age compare, budget
// check and free-byte update all pass through it, one use per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcb_unit (
  input  wire lcb_pkg::unit_op_t          op,
  input  wire logic [lcb_pkg::UNIT_W-1:0] a,
  input  wire logic [lcb_pkg::UNIT_W-1:0] b,
  output lcb_pkg::unit_res_t              res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
    case (op)
      lcb_pkg::OP_ADD: res.res = a + b;
      lcb_pkg::OP_SUB: res.res = a - b;
      default:         res.res = a + b;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/lcb_table.sv @@
// ----------------------------------------------------------------------------
// lcb_table
// Entry table memory: one row per slot holding key, size and recency stamp.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcb_table #(
  parameter int ENTRIES = lcb_pkg::ENTRIES_DEF,
  parameter int ROW_W   = lcb_pkg::KEY_BITS_DEF + 96
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  wire logic [ROW_W-1:0]           wr_data,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic      [ROW_W-1:0]           rd_data
);

  logic [ROW_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/lru_cache_byte_budget.sv @@
// Request flow, accepting edge to result word: a hit ends at its slot in the sequential key scan
// through the single registered table read port. A miss that finds a free slot then passes the
// budget check and stores. Each budget eviction adds an oldest-entry scan and a drop, then a new
// budget check; a full-table eviction goes from the drop to the store; a reject ends on a last empty scan.
// Throughput: one request at a time; input is ready the cycle after the result word loads.
// Reset (rst, synchronous): all entries invalid, stamp 1, capacity 1048576, free = capacity.
// ----------------------------------------------------------------------------
// lru_cache_byte_budget
// LRU cache bookkeeping with a byte budget. A small sequencer scans the entry
// table for a key match, evicts oldest entries until the item fits and stores
// it (or rejects it once the table is empty), using one shared compare/arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_byte_budget #(
  parameter int ENTRIES  = lcb_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lcb_pkg::KEY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: key_id[31:0], item_size[63:32]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,
  // m_tdata: hit[0], stored[1], evicted_count[6:2], free_after[38:7], zero[39]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int SW    = lcb_pkg::SIZE_W;
  localparam int TW    = lcb_pkg::STAMP_W;
  localparam int ROW_W = KW + SW + TW;

  lcb_pkg::state_t state, state_next;

  logic [31:0]        capacity;
  logic [SW-1:0]      free_bytes;
  logic [TW-1:0]      stamp;
  logic [TW-1:0]      stamp_inc;
  logic [ENTRIES-1:0] valid;

  logic [KW-1:0] key_q;
  logic [SW-1:0] size_q;

  logic [IW:0]   cnt;
  logic          chk;
  logic [IW-1:0] chk_idx;
  logic          last_chk;

  logic          best_found;
  logic [IW-1:0] best_idx;
  logic [TW-1:0] best_stamp;
  logic [SW-1:0] best_size;
  logic          free_found;
  logic [IW-1:0] free_slot;
  logic          full_mode;

  logic       res_hit;
  logic       res_stored;
  logic [4:0] evicted;

  logic [ROW_W-1:0] rd_row;
  logic [KW-1:0]    rd_key;
  logic [SW-1:0]    rd_size;
  logic [TW-1:0]    rd_stamp;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_data;

  lcb_pkg::unit_op_t             op;
  logic [lcb_pkg::UNIT_W-1:0]    op_a;
  logic [lcb_pkg::UNIT_W-1:0]    op_b;
  lcb_pkg::unit_res_t            ures;

  logic hit_now;
  logic take_old;
  logic cfg_we;

  assign rd_key    = rd_row[ROW_W-1 -: KW];
  assign rd_size   = rd_row[TW +: SW];
  assign rd_stamp  = rd_row[TW-1:0];
  assign stamp_inc = stamp + 64'd1;
  assign last_chk  = chk && (chk_idx == IW'(ENTRIES - 1));
  assign hit_now   = (state == lcb_pkg::S_LOOK) && chk && valid[chk_idx] && ures.eq;
  assign take_old  = chk && valid[chk_idx] && (!best_found || ures.lt);

  assign s_tready = (state == lcb_pkg::S_IDLE);
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && (paddr[2] == lcb_pkg::REG_CAPACITY);
  assign prdata   = (paddr[2] == lcb_pkg::REG_CAPACITY) ? capacity : 32'd0;

  lcb_table #(
    .ENTRIES(ENTRIES),
    .ROW_W  (ROW_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(cnt[IW-1:0]),
    .rd_data(rd_row)
  );

  lcb_unit u_unit (
    .op (op),
    .a  (op_a),
    .b  (op_b),
    .res(ures)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lcb_pkg::S_IDLE: begin
        if (s_tvalid) state_next = lcb_pkg::S_LOOK;
      end
      lcb_pkg::S_LOOK: begin
        if (hit_now) state_next = lcb_pkg::S_DONE;
        else if (last_chk) state_next = lcb_pkg::S_FIT;
      end
      lcb_pkg::S_FIT: begin
        if (ures.lt || !free_found) state_next = lcb_pkg::S_OLD;
        else state_next = lcb_pkg::S_STORE;
      end
      lcb_pkg::S_OLD: begin
        if (last_chk) state_next = lcb_pkg::S_DROP;
      end
      lcb_pkg::S_DROP: begin
        if (!best_found) state_next = lcb_pkg::S_DONE;
        else if (full_mode) state_next = lcb_pkg::S_STORE;
        else state_next = lcb_pkg::S_FIT;
      end
      lcb_pkg::S_STORE: state_next = lcb_pkg::S_DONE;
      lcb_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) state_next = lcb_pkg::S_IDLE;
      end
      default: state_next = lcb_pkg::S_IDLE;
    endcase
  end

  // Shared unit operands and table writes.
  always_comb begin
    op      = lcb_pkg::OP_ADD;
    op_a    = '0;
    op_b    = '0;
    wr_en   = 1'b0;
    wr_addr = chk_idx;
    wr_data = {rd_key, rd_size, stamp_inc};
    case (state)
      lcb_pkg::S_LOOK: begin
        op_a  = 64'(rd_key);
        op_b  = 64'(key_q);
        wr_en = hit_now;
      end
      lcb_pkg::S_FIT: begin
        // Compare as free < size: the item does not fit yet.
        op_a = 64'(free_bytes);
        op_b = 64'(size_q);
      end
      lcb_pkg::S_OLD: begin
        op_a = rd_stamp;
        op_b = best_stamp;
      end
      lcb_pkg::S_DROP: begin
        op_a = 64'(free_bytes);
        op_b = 64'(best_size);
      end
      lcb_pkg::S_STORE: begin
        op      = lcb_pkg::OP_SUB;
        op_a    = 64'(free_bytes);
        op_b    = 64'(size_q);
        wr_en   = 1'b1;
        wr_addr = free_slot;
        wr_data = {key_q, size_q, stamp_inc};
      end
      default: begin
        op = lcb_pkg::OP_ADD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lcb_pkg::S_IDLE;
      capacity   <= lcb_pkg::CAPACITY_RESET;
      free_bytes <= lcb_pkg::CAPACITY_RESET;
      stamp      <= 64'd1;
      valid      <= '0;
      cnt        <= '0;
      chk        <= 1'b0;
      best_found <= 1'b0;
      free_found <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      if (state == lcb_pkg::S_LOOK || state == lcb_pkg::S_OLD) begin
        if (cnt < (IW+1)'(ENTRIES)) begin
          cnt <= cnt + (IW+1)'(1);
          chk <= 1'b1;
        end else begin
          chk <= 1'b0;
        end
      end else begin
        cnt <= '0;
        chk <= 1'b0;
      end

      case (state)
        lcb_pkg::S_IDLE: begin
          free_found <= 1'b0;
        end
        lcb_pkg::S_LOOK: begin
          // Remember the lowest empty slot seen during the key scan.
          if (chk && !valid[chk_idx] && !free_found) free_found <= 1'b1;
          if (hit_now) stamp <= stamp_inc;
        end
        lcb_pkg::S_FIT: begin
          best_found <= 1'b0;
        end
        lcb_pkg::S_OLD: begin
          if (take_old) best_found <= 1'b1;
        end
        lcb_pkg::S_DROP: begin
          if (best_found) begin
            free_bytes      <= ures.res[SW-1:0];
            valid[best_idx] <= 1'b0;
            free_found      <= 1'b1;
          end
        end
        lcb_pkg::S_STORE: begin
          valid[free_slot] <= 1'b1;
          stamp            <= stamp_inc;
          free_bytes       <= ures.res[SW-1:0];
        end
        default: begin
          stamp <= stamp;
        end
      endcase

      if (state == lcb_pkg::S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      if (cfg_we) begin
        capacity   <= pwdata;
        free_bytes <= pwdata;
        valid      <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == lcb_pkg::S_LOOK || state == lcb_pkg::S_OLD) begin
      chk_idx <= cnt[IW-1:0];
    end
    case (state)
      lcb_pkg::S_IDLE: begin
        key_q      <= s_tdata[KW-1:0];
        size_q     <= s_tdata[63:32];
        res_hit    <= 1'b0;
        res_stored <= 1'b0;
        evicted    <= 5'd0;
      end
      lcb_pkg::S_LOOK: begin
        if (chk && !valid[chk_idx] && !free_found) free_slot <= chk_idx;
        if (hit_now) begin
          res_hit    <= 1'b1;
          res_stored <= 1'b1;
        end
      end
      lcb_pkg::S_FIT: begin
        full_mode <= !ures.lt;
      end
      lcb_pkg::S_OLD: begin
        if (take_old) begin
          best_idx   <= chk_idx;
          best_stamp <= rd_stamp;
          best_size  <= rd_size;
        end
      end
      lcb_pkg::S_DROP: begin
        if (best_found) begin
          evicted <= evicted + 5'd1;
          if (!free_found || best_idx < free_slot) free_slot <= best_idx;
        end
      end
      lcb_pkg::S_STORE: begin
        res_stored <= 1'b1;
      end
      lcb_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {1'b0, free_bytes, evicted, res_stored, res_hit};
        end
      end
      default: begin
        res_hit <= res_hit;
      end
    endcase
  end

  // The budget is never overrun: free bytes never exceed capacity.
  a_free_within_capacity: assert property (@(posedge clk) disable iff (rst)
    free_bytes <= capacity)
    else $error("free bytes exceed capacity");

  // An eviction always targets an entry that is currently valid.
  a_drop_valid: assert property (@(posedge clk) disable iff (rst)
    (state == lcb_pkg::S_DROP && best_found) |-> valid[best_idx])
    else $error("eviction of an invalid entry");

  // A stored item occupies a slot that was empty before the store.
  a_store_slot: assert property (@(posedge clk) disable iff (rst)
    (state == lcb_pkg::S_STORE) |-> (free_found && !valid[free_slot]))
    else $error("store into an occupied slot");

  // Stored slot is valid right after the store, unless a capacity write clears the table at the same time.
  a_store_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == lcb_pkg::S_STORE && !cfg_we) |=> valid[$past(free_slot)])
    else $error("stored slot not valid");

  // A reject leaves the table empty.
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (state == lcb_pkg::S_DROP && !best_found) |-> (valid == '0))
    else $error("reject with entries left");

endmodule

`default_nettype wire
